// File: rtl/blom_pkg.sv
// Package for the back/lay order matcher: payload structs, slot entry layout,
// result kind codes and sizing constants. No dependencies.
package blom_pkg;

  localparam int ORDER_SLOTS = 32;
  localparam int MAX_MARKETS = 32;
  localparam int SLOT_W      = $clog2(ORDER_SLOTS);
  localparam int MKT_CMP_W   = 10;

  localparam logic [2:0] KIND_TRADE   = 3'd0;
  localparam logic [2:0] KIND_RESTED  = 3'd1;
  localparam logic [2:0] KIND_DONE    = 3'd2;
  localparam logic [2:0] KIND_DROPPED = 3'd3;
  localparam logic [2:0] KIND_UNKNOWN = 3'd4;

  localparam logic [5:0] MARKET_COUNT_RESET = 6'd32;

  typedef struct packed {
    logic [4:0]  market;
    logic        side;
    logic [15:0] order_price;
    logic [15:0] order_qty;
    logic [15:0] user_id;
  } in_t;

  typedef struct packed {
    logic [2:0]  kind;
    logic [15:0] back_user;
    logic [15:0] lay_user;
    logic [15:0] trade_odds;
    logic [15:0] trade_qty;
    logic [15:0] left_qty;
    logic        last;
  } out_t;

  // One resting order as kept in the slot memory.
  typedef struct packed {
    logic [4:0]  market;
    logic        side;
    logic [15:0] price;
    logic [15:0] qty;
    logic [15:0] user;
    logic [15:0] age;
  } slot_t;

  // Incoming order context seen by the selection unit.
  typedef struct packed {
    logic [4:0]  market;
    logic        side;
    logic [15:0] price;
    logic [15:0] arrival;
  } ctx_t;

  // Outcome of one pass over the slots.
  typedef struct packed {
    logic              found;
    logic [SLOT_W-1:0] idx;
    slot_t             entry;
    logic              free_found;
    logic [SLOT_W-1:0] free_idx;
  } sel_t;

endpackage

// File: rtl/blom_slot_mem.sv
// Slot memory of the order matcher: one write port, one registered read port.
// Depends on blom_pkg for the entry layout and depth.
module blom_slot_mem import blom_pkg::*; (
  input  logic              clk,
  input  logic              we,
  input  logic [SLOT_W-1:0] waddr,
  input  slot_t             wdata,
  input  logic [SLOT_W-1:0] raddr,
  output slot_t             rdata
);

  slot_t mem [ORDER_SLOTS];

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port.
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

// File: rtl/blom_select.sv
// Shared compare unit: while cand_en is high, looks at one slot per cycle and
// keeps the best crossing counter-order (price, then age, then lowest index)
// and the first free slot. Depends on blom_pkg.
module blom_select import blom_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              clear,
  input  logic              cand_en,
  input  logic [SLOT_W-1:0] cand_idx,
  input  logic              cand_vld,
  input  slot_t             cand,
  input  ctx_t              ctx,
  output sel_t              sel
);

  logic        eligible;
  logic        crosses;
  logic        better;
  logic [15:0] age_gap;
  logic [15:0] best_dist;

  // Candidate checks against the incoming order.
  always_comb begin
    age_gap  = ctx.arrival - cand.age;
    crosses  = ctx.side ? (cand.price >= ctx.price) : (ctx.price >= cand.price);
    eligible = cand_vld && (cand.market == ctx.market) && (cand.side != ctx.side)
               && crosses;
    if (!sel.found) begin
      better = 1'b1;
    end else if (cand.price != sel.entry.price) begin
      better = ctx.side ? (cand.price > sel.entry.price)
                        : (cand.price < sel.entry.price);
    end else begin
      better = age_gap > best_dist;
    end
  end

  // Running best and first free slot.
  always_ff @(posedge clk) begin
    if (rst || clear) begin
      sel.found      <= 1'b0;
      sel.free_found <= 1'b0;
    end else if (cand_en) begin
      if (eligible && better) begin
        sel.found <= 1'b1;
        sel.idx   <= cand_idx;
        sel.entry <= cand;
        best_dist <= age_gap;
      end
      if (!cand_vld && !sel.free_found) begin
        sel.free_found <= 1'b1;
        sel.free_idx   <= cand_idx;
      end
    end
  end

endmodule

// File: rtl/back_lay_order_matcher.sv
// Top level of the back/lay order matcher: sequencer, slot valid bits and
// result register. Depends on blom_pkg, blom_slot_mem and blom_select.
//
// Usage: raise start with an order on the order port; it is taken at a clock
// edge where start is high and busy is low. Results appear on res for one
// cycle each, marked by res_valid; the receiver cannot stall them. Each order
// gives zero or more trade beats followed by exactly one status beat with
// last set.
// An order for an unknown market or with zero quantity answers in the cycle
// after acceptance and keeps busy low. Otherwise each trade takes one pass
// over the 32 slots through the shared compare unit: the scan state reads
// one slot per cycle from the registered read port, then the decide state
// acts on the best match. The final pass that finds no match also finds the
// free slot; when the last trade fills the order, a status state follows.
// The market_count register is written with cfg_we/cfg_data; the user must
// write it only while idle, as the block does not enforce this.
// Reset (rst, synchronous) empties the book, clears the arrival counter and
// sets market_count to 32; the slot memory itself is not cleared.
module back_lay_order_matcher import blom_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       start,
  output logic       busy,
  input  in_t        order,
  input  logic       cfg_we,
  input  logic [5:0] cfg_data,
  output logic       res_valid,
  output out_t       res
);

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_SCAN   = 2'd1;
  localparam logic [1:0] ST_DECIDE = 2'd2;
  localparam logic [1:0] ST_STATUS = 2'd3;

  logic [1:0]             state;
  in_t                    ord;
  logic [15:0]            left;
  logic [15:0]            arrival;
  logic [5:0]             market_count;
  logic [ORDER_SLOTS-1:0] slot_valid;
  logic [SLOT_W:0]        cnt;
  logic                   rd_pend;
  logic [SLOT_W-1:0]      rd_idx;
  logic                   rd_vld;
  logic                   clear_sel;

  logic                   mem_we;
  logic [SLOT_W-1:0]      mem_waddr;
  slot_t                  mem_wdata;
  slot_t                  mem_rdata;
  ctx_t                   ctx;
  sel_t                   sel;

  logic [15:0]            fill_qty;
  logic [15:0]            rest_qty;
  logic                   unknown;

  assign busy = (state != ST_IDLE);

  assign ctx.market  = ord.market;
  assign ctx.side    = ord.side;
  assign ctx.price   = ord.order_price;
  assign ctx.arrival = arrival;

  assign unknown = (MKT_CMP_W'(order.market) >= MKT_CMP_W'(market_count))
                || (MKT_CMP_W'(order.market) >= MKT_CMP_W'(MAX_MARKETS));

  // Fill size of the chosen resting order.
  always_comb begin
    fill_qty = (left < sel.entry.qty) ? left : sel.entry.qty;
    rest_qty = sel.entry.qty - fill_qty;
  end

  // Memory write: shrink a filled slot or store a remainder.
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = sel.idx;
    mem_wdata = sel.entry;
    if (state == ST_DECIDE) begin
      if (sel.found) begin
        mem_we        = 1'b1;
        mem_wdata.qty = rest_qty;
      end else if (sel.free_found) begin
        mem_we    = 1'b1;
        mem_waddr = sel.free_idx;
        mem_wdata = '{market: ord.market, side: ord.side, price: ord.order_price,
                      qty: left, user: ord.user_id, age: arrival};
      end
    end
  end

  blom_slot_mem u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (cnt[SLOT_W-1:0]),
    .rdata (mem_rdata)
  );

  blom_select u_sel (
    .clk      (clk),
    .rst      (rst),
    .clear    (clear_sel),
    .cand_en  (rd_pend),
    .cand_idx (rd_idx),
    .cand_vld (rd_vld),
    .cand     (mem_rdata),
    .ctx      (ctx),
    .sel      (sel)
  );

  // Read pipeline alongside the memory latency.
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_pend <= 1'b0;
    end else begin
      rd_pend <= (state == ST_SCAN) && (cnt < (SLOT_W + 1)'(ORDER_SLOTS));
      rd_idx  <= cnt[SLOT_W-1:0];
      rd_vld  <= slot_valid[cnt[SLOT_W-1:0]];
    end
  end

  // Sequencer, book control state and result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      arrival      <= '0;
      market_count <= MARKET_COUNT_RESET;
      slot_valid   <= '0;
      res_valid    <= 1'b0;
      clear_sel    <= 1'b0;
      cnt          <= '0;
    end else begin
      res_valid <= 1'b0;
      clear_sel <= 1'b0;
      if (cfg_we) begin
        market_count <= cfg_data;
      end
      unique case (state)
        ST_IDLE: begin
          if (start) begin
            ord  <= order;
            left <= order.order_qty;
            res  <= '0;
            if (unknown) begin
              res_valid    <= 1'b1;
              res.kind     <= KIND_UNKNOWN;
              res.left_qty <= order.order_qty;
              res.last     <= 1'b1;
            end else if (order.order_qty == '0) begin
              res_valid <= 1'b1;
              res.kind  <= KIND_DONE;
              res.last  <= 1'b1;
            end else begin
              state     <= ST_SCAN;
              cnt       <= '0;
              clear_sel <= 1'b1;
            end
          end
        end
        ST_SCAN: begin
          if (cnt == (SLOT_W + 1)'(ORDER_SLOTS)) begin
            state <= ST_DECIDE;
          end else begin
            cnt <= cnt + 1'b1;
          end
        end
        ST_DECIDE: begin
          res_valid <= 1'b1;
          res       <= '0;
          if (sel.found) begin
            res.kind       <= KIND_TRADE;
            res.back_user  <= ord.side ? sel.entry.user : ord.user_id;
            res.lay_user   <= ord.side ? ord.user_id : sel.entry.user;
            res.trade_odds <= sel.entry.price;
            res.trade_qty  <= fill_qty;
            res.left_qty   <= left - fill_qty;
            left           <= left - fill_qty;
            if (rest_qty == '0) begin
              slot_valid[sel.idx] <= 1'b0;
            end
            if (left == fill_qty) begin
              state <= ST_STATUS;
            end else begin
              state     <= ST_SCAN;
              cnt       <= '0;
              clear_sel <= 1'b1;
            end
          end else begin
            res.left_qty <= left;
            res.last     <= 1'b1;
            arrival      <= arrival + 1'b1;
            state        <= ST_IDLE;
            if (sel.free_found) begin
              res.kind                 <= KIND_RESTED;
              slot_valid[sel.free_idx] <= 1'b1;
            end else begin
              res.kind <= KIND_DROPPED;
            end
          end
        end
        ST_STATUS: begin
          res_valid <= 1'b1;
          res       <= '0;
          res.kind  <= KIND_DONE;
          res.last  <= 1'b1;
          arrival   <= arrival + 1'b1;
          state     <= ST_IDLE;
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

// File: rtl/blom_checker.sv
// Port-level checker for the order matcher and its bind to the top level.
// Depends on blom_pkg.
module blom_checker import blom_pkg::*; (
  input logic clk,
  input logic rst,
  input logic start,
  input logic busy,
  input logic res_valid,
  input out_t res
);

  // A trade beat is always followed by more beats, so the block stays busy.
  a_trade_busy: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res.last |-> busy)
    else $error("trade beat shown while not busy");

  // An accepted order either answers at once or makes the block busy.
  a_accept: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy || (res_valid && res.last))
    else $error("accepted order neither answered nor started");

  // Trades never close an order.
  a_trade_not_last: assert property (@(posedge clk) disable iff (rst)
    res_valid && res.kind == KIND_TRADE |-> !res.last)
    else $error("trade beat marked last");

  // A fully done status leaves nothing unmatched.
  a_done_zero: assert property (@(posedge clk) disable iff (rst)
    res_valid && res.kind == KIND_DONE |-> res.left_qty == '0 && res.last)
    else $error("done status with remainder");

endmodule

bind back_lay_order_matcher blom_checker u_blom_checker (
  .clk       (clk),
  .rst       (rst),
  .start     (start),
  .busy      (busy),
  .res_valid (res_valid),
  .res       (res)
);
